/* hdl/bbmq_pkg.sv */
`default_nettype none

package bbmq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam logic [31:0] ByteCapacityReset = 32'd16777216;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] size;
  } desc_t;

endpackage

`default_nettype wire

/* hdl/bbmq_desc_mem.sv */
`default_nettype none

module bbmq_desc_mem #(
  parameter int unsigned QUEUE_DEPTH = bbmq_pkg::QueueDepthDefault
) (
  input  wire                             clk,
  input  wire                             wr_en,
  input  wire  [$clog2(QUEUE_DEPTH)-1:0]  wr_addr,
  input  wire  bbmq_pkg::desc_t           wr_data,
  input  wire                             rd_en,
  input  wire  [$clog2(QUEUE_DEPTH)-1:0]  rd_addr,
  output bbmq_pkg::desc_t                 rd_data
);

  bbmq_pkg::desc_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/byte_budget_message_queue.sv */
`default_nettype none

// Channel   Handshake            Payload
// ------    -------------------  -----------------------------------------------
// input     in_valid / in_stall  mode, payload_size, payload_handle
// output    out_valid/ out_stall push_accepted, pop_valid, popped_handle,
//                                popped_size, bytes_queued, peak_bytes,
//                                drop_total, is_closed
// config    cfg_valid/ cfg_ready cfg_data (byte_capacity)
//
// Each request is taken into the pending stage while the head descriptor is read
// from the single-port-read descriptor memory; from there the accounting is updated
// and the memory written. The input takes no new request while one is pending.
// Reset is synchronous, clears pointers, counters and flags, and restores the
// default budget.
// A stalled result holds in the output register; the next request is taken
// and waits in the pending stage until that result leaves.

module byte_budget_message_queue #(
  parameter int unsigned QUEUE_DEPTH = bbmq_pkg::QueueDepthDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  mode,
  input  wire  [31:0] payload_size,
  input  wire  [31:0] payload_handle,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        push_accepted,
  output logic        pop_valid,
  output logic [31:0] popped_handle,
  output logic [31:0] popped_size,
  output logic [31:0] bytes_queued,
  output logic [31:0] peak_bytes,
  output logic [31:0] drop_total,
  output logic        is_closed,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_data
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QUEUE_DEPTH);

  logic [31:0]     byte_capacity;
  logic            pend_valid;
  logic [1:0]      pend_mode;
  logic [31:0]     pend_size;
  logic [31:0]     pend_handle;
  logic [PtrW-1:0] head_ptr, head_ptr_next;
  logic [PtrW-1:0] tail_ptr, tail_ptr_next;
  logic [CntW-1:0] entry_count, entry_count_next;
  logic [31:0]     queued_total, queued_total_next;
  logic [31:0]     watermark, watermark_next;
  logic [31:0]     drop_counter, drop_counter_next;
  logic            closed_flag, closed_flag_next;

  logic            in_take;
  logic            out_free;
  logic            step;
  logic            drop;
  logic            push_ok;
  logic            pop_ok;
  bbmq_pkg::desc_t rd_desc;
  bbmq_pkg::desc_t wr_desc;

  assign cfg_ready = 1'b1;
  assign in_stall  = pend_valid;
  assign in_take   = in_valid && !pend_valid;
  assign out_free  = !out_valid || !out_stall;
  assign step      = pend_valid && out_free;

  assign drop = closed_flag
             || (pend_size > byte_capacity)
             || (queued_total > (byte_capacity - pend_size))
             || (entry_count >= FullCount);
  assign push_ok = (pend_mode == bbmq_pkg::MODE_PUSH) && !drop;
  assign pop_ok  = (pend_mode == bbmq_pkg::MODE_POP) && (entry_count != '0);

  assign wr_desc.handle = pend_handle;
  assign wr_desc.size   = pend_size;

  bbmq_desc_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_desc_mem (
    .clk     (clk),
    .wr_en   (step && push_ok),
    .wr_addr (tail_ptr),
    .wr_data (wr_desc),
    .rd_en   (in_take),
    .rd_addr (head_ptr),
    .rd_data (rd_desc)
  );

  always_comb begin
    head_ptr_next     = head_ptr;
    tail_ptr_next     = tail_ptr;
    entry_count_next  = entry_count;
    queued_total_next = queued_total;
    watermark_next    = watermark;
    drop_counter_next = drop_counter;
    closed_flag_next  = closed_flag;
    unique case (pend_mode)
      bbmq_pkg::MODE_PUSH: begin
        if (drop) begin
          if (drop_counter != '1) begin
            drop_counter_next = drop_counter + 32'd1;
          end
        end else begin
          tail_ptr_next     = (tail_ptr == LastSlot) ? '0 : tail_ptr + PtrW'(1);
          entry_count_next  = entry_count + CntW'(1);
          queued_total_next = queued_total + pend_size;
          if (queued_total_next > watermark) begin
            watermark_next = queued_total_next;
          end
        end
      end
      bbmq_pkg::MODE_POP: begin
        if (pop_ok) begin
          head_ptr_next     = (head_ptr == LastSlot) ? '0 : head_ptr + PtrW'(1);
          entry_count_next  = entry_count - CntW'(1);
          queued_total_next = queued_total - rd_desc.size;
        end
      end
      bbmq_pkg::MODE_CLOSE: begin
        closed_flag_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // hold the request while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_take) begin
      pend_valid <= 1'b1;
    end else if (step) begin
      pend_valid <= 1'b0;
    end
    if (in_take) begin
      pend_mode   <= mode;
      pend_size   <= payload_size;
      pend_handle <= payload_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_capacity <= bbmq_pkg::ByteCapacityReset;
    end else if (cfg_valid && cfg_ready) begin
      byte_capacity <= cfg_data;
    end
  end

  // advance the queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr     <= '0;
      tail_ptr     <= '0;
      entry_count  <= '0;
      queued_total <= '0;
      watermark    <= '0;
      drop_counter <= '0;
      closed_flag  <= 1'b0;
    end else if (step) begin
      head_ptr     <= head_ptr_next;
      tail_ptr     <= tail_ptr_next;
      entry_count  <= entry_count_next;
      queued_total <= queued_total_next;
      watermark    <= watermark_next;
      drop_counter <= drop_counter_next;
      closed_flag  <= closed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      push_accepted <= push_ok;
      pop_valid     <= pop_ok;
      popped_handle <= pop_ok ? rd_desc.handle : 32'd0;
      popped_size   <= pop_ok ? rd_desc.size : 32'd0;
      bytes_queued  <= queued_total_next;
      peak_bytes    <= watermark_next;
      drop_total    <= drop_counter_next;
      is_closed     <= closed_flag_next;
    end
  end

endmodule

`default_nettype wire
